// ===== src/range_add_range_sum_tree_defines.svh =====
// Assertion macros for the range add / range sum tree checker.
// Used only by rarst_check; relies on clock and reset in the using scope.
`ifndef RANGE_ADD_RANGE_SUM_TREE_DEFINES_SVH
`define RANGE_ADD_RANGE_SUM_TREE_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define RARST_AP_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rarst: same-cycle check failed");

// next-cycle implication, ignored while reset is high
`define RARST_AP_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rarst: next-cycle check failed");

// next-cycle implication that also watches reset itself
`define RARST_AP_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("rarst: reset check failed");

`endif

// ===== src/rarst_pkg.sv =====
// Shared types and constants for the range add / range sum tree.
// No dependencies.
package rarst_pkg;

   localparam int IDX_W       = 10;
   localparam int DATA_W      = 64;
   localparam int NODE_W      = 2 * DATA_W;   // {sum, tag}
   localparam int SLOT_W      = 2;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 64;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_SUM = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic step;
      logic mem_rd;
      logic mul;
      logic acc;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic nonempty;
      logic visit;
      logic last_step;
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== src/rarst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rarst_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rarst_ctrl.sv =====
// Sequencer for the tree walk: clear pass, accept, node visits, result load.
// Depends on rarst_pkg.
module rarst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  rarst_pkg::dp_status_type status,
   output rarst_pkg::ctl_cmd_type   cmd
);
   import rarst_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = status.nonempty ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (status.visit) begin
               state_in = ST_READ;
            end else begin
               cmd.step = 1'b1;
               if (status.last_step) state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            cmd.step = 1'b1;
            state_in = status.last_step ? ST_DONE : ST_SCAN;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

// ===== src/rarst_dp.sv =====
// Datapath: operand registers, level/slot walker, node RAM, multiplier, result register.
// Depends on rarst_pkg and rarst_ram.
module rarst_dp #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rarst_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                              req_tuser,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [rarst_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                              rsp_tuser,
   input  rarst_pkg::ctl_cmd_type             cmd,
   output rarst_pkg::dp_status_type           status
);
   import rarst_pkg::*;

   localparam int DEPTH_LOG  = $clog2(LEAF_COUNT);
   localparam int NODE_AW    = DEPTH_LOG + 1;
   localparam int NODE_DEPTH = 2 ** NODE_AW;
   localparam int CNT_W      = DEPTH_LOG + 1;
   localparam int LVL_W      = $clog2(DEPTH_LOG + 1);
   localparam int XW         = (DEPTH_LOG > IDX_W) ? DEPTH_LOG : IDX_W;
   localparam int PW         = 32 + CNT_W;

   // input beat decode and range clamp
   logic [IDX_W-1:0]  in_left, in_right;
   logic [DATA_W-1:0] in_amount;
   logic [XW-1:0]     in_l_x, in_r_x, in_r_cl, last_x;

   assign in_left   = req_tdata[IDX_W-1:0];
   assign in_right  = req_tdata[2*IDX_W-1:IDX_W];
   assign in_amount = req_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
   assign in_l_x    = XW'(in_left);
   assign in_r_x    = XW'(in_right);
   assign last_x    = XW'(LEAF_COUNT - 1);
   assign in_r_cl   = (in_r_x > last_x) ? last_x : in_r_x;

   // operation registers
   logic                 cmd_ff;
   logic [DEPTH_LOG-1:0] l_ff, r_ff;
   logic [DATA_W-1:0]    amt_ff, acc_ff;
   logic [LVL_W-1:0]     level_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [NODE_AW-1:0]   clr_ff;

   // candidate node at (level, slot)
   logic [DEPTH_LOG-1:0] ones, par_l, par_r, par_sel, cand_j, lo, hi, plo, phi;
   logic [DEPTH_LOG-1:0] ov_lo, ov_hi;
   logic                 inter, cov, pcov, dup, visit;
   logic [CNT_W-1:0]     ov;
   logic [NODE_AW-1:0]   addr;
   int unsigned          shamt;

   assign ones = '1;

   always_comb begin
      shamt   = DEPTH_LOG - 32'(level_ff);
      par_l   = l_ff >> (shamt + 1);
      par_r   = r_ff >> (shamt + 1);
      par_sel = slot_ff[1] ? par_r : par_l;
      cand_j  = (level_ff == '0) ? '0 : ((par_sel << 1) | DEPTH_LOG'(slot_ff[0]));
      lo      = cand_j << shamt;
      hi      = lo | ~(ones << shamt);
      plo     = par_sel << (shamt + 1);
      phi     = plo | ~(ones << (shamt + 1));
      inter   = (lo <= r_ff) && (hi >= l_ff);
      cov     = (l_ff <= lo) && (hi <= r_ff);
      pcov    = (l_ff <= plo) && (phi <= r_ff);
      dup     = slot_ff[1] && (par_r == par_l);
      visit   = inter && !dup && ((level_ff == '0) ? (slot_ff == '0) : !pcov);
      ov_hi   = (hi < r_ff) ? hi : r_ff;
      ov_lo   = (lo > l_ff) ? lo : l_ff;
      ov      = CNT_W'(ov_hi) - CNT_W'(ov_lo) + CNT_W'(1);
      addr    = (NODE_AW'(1) << level_ff) | NODE_AW'(cand_j);
   end

   // node registers, refreshed every cycle (stable while one node is in flight)
   logic [NODE_AW-1:0] addr_ff;
   logic [CNT_W-1:0]   ov_ff;
   logic               cov_ff;

   always_ff @(posedge clock) begin
      addr_ff <= addr;
      ov_ff   <= ov;
      cov_ff  <= cov;
   end

   // node memory {sum, tag}
   logic               wr_en;
   logic [NODE_AW-1:0] wr_addr;
   logic [NODE_W-1:0]  wr_data, rd_data, rd_ff;
   logic [PW-1:0]      pl_ff, ph_ff;
   logic [DATA_W-1:0]  mul_a, prod, tag_new;

   assign mul_a   = (cmd_ff == CMD_ADD) ? amt_ff : rd_data[DATA_W-1:0];
   assign prod    = DATA_W'(pl_ff) + {ph_ff[31:0], 32'b0};
   assign tag_new = rd_ff[DATA_W-1:0] + (cov_ff ? amt_ff : '0);
   assign wr_en   = cmd.clear_wr || (cmd.acc && (cmd_ff == CMD_ADD));
   assign wr_addr = cmd.clear_wr ? clr_ff : addr_ff;
   assign wr_data = cmd.clear_wr ? '0 : {rd_ff[NODE_W-1:DATA_W] + prod, tag_new};

   rarst_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.mem_rd),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // split 64 x CNT_W multiply, one stage
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         pl_ff <= PW'(mul_a[31:0]) * PW'(ov_ff);
         ph_ff <= PW'(mul_a[63:32]) * PW'(ov_ff);
         rd_ff <= rd_data;
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff <= req_tuser;
         l_ff   <= in_l_x[DEPTH_LOG-1:0];
         r_ff   <= in_r_cl[DEPTH_LOG-1:0];
         amt_ff <= in_amount;
         acc_ff <= '0;
      end else if (cmd.acc && (cmd_ff == CMD_SUM)) begin
         acc_ff <= acc_ff + (cov_ff ? rd_ff[NODE_W-1:DATA_W] : prod);
      end
   end

   // walker and clear counter
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         slot_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         if (cmd.clear_wr) clr_ff <= clr_ff + NODE_AW'(1);
         if (cmd.accept) begin
            level_ff <= '0;
            slot_ff  <= '0;
         end else if (cmd.step) begin
            if ((slot_ff == '1) || (level_ff == '0)) begin
               slot_ff  <= '0;
               level_ff <= level_ff + LVL_W'(1);
            end else begin
               slot_ff <= slot_ff + SLOT_W'(1);
            end
         end
      end
   end

   // result register
   logic              rsp_valid_ff, rsp_query_ff;
   logic [DATA_W-1:0] rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_total_ff <= acc_ff;
         rsp_query_ff <= cmd_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_total_ff;
   assign rsp_tuser  = rsp_query_ff;

   // status back to the sequencer
   assign status.clear_done = &clr_ff;
   assign status.nonempty   = in_l_x <= in_r_cl;
   assign status.visit      = visit;
   assign status.last_step  = (level_ff == LVL_W'(DEPTH_LOG)) && (slot_ff == '1);
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

// ===== src/range_add_range_sum_tree.sv =====
// Top level of the range add / range sum tree.
// Depends on rarst_pkg, rarst_ctrl, rarst_dp.
//
// Usage:
//   req channel: one beat per command. tuser = command (0 add, 1 sum);
//     tdata = left_index, right_index, add_amount from the lowest bit up.
//   rsp channel: exactly one beat per command, in order. tdata = range_total
//     (zero for adds), tuser = was_query.
//   Right index is clamped to LEAF_COUNT-1; left above right is an empty range.
// Sequencing:
//   One command at a time. A nonempty command scans 1 + 4*D candidate nodes,
//   D = clog2(LEAF_COUNT), and each node actually visited adds a RAM read,
//   a multiply stage and a read-modify-write. Up to about 4 nodes are visited
//   per level. An empty range goes from accept straight to the result load.
//   The single node RAM port pair limits the pace of the walk.
// Reset: a clearing pass writes every node slot, 2*2^D of them (2048 at 1024
//   leaves), with req_tready low. A stalled result sits in the output register
//   while the next command is accepted; its result waits until that register frees.
module range_add_range_sum_tree #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] left_index, [19:10] right_index, [83:20] add_amount, [87:84] zero
   input  logic [rarst_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] command
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [63:0] range_total
   output logic [rarst_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] was_query
   output logic [0:0]                        rsp_tuser
);
   import rarst_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   rarst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rarst_dp #(
      .LEAF_COUNT (LEAF_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser[0]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser[0]),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== src/rarst_check.sv =====
// Port-level checker for range_add_range_sum_tree, bound to the top level.
// Depends on rarst_pkg and range_add_range_sum_tree_defines.svh.
`include "range_add_range_sum_tree_defines.svh"

module rarst_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [rarst_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic [0:0]                        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rarst_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]                        rsp_tuser
);

   // whole result beat, tuser over tdata
   logic [rarst_pkg::RSP_TDATA_W:0] rsp_beat;

   assign rsp_beat = {rsp_tuser, rsp_tdata};

   // stalled result beat holds
   `RARST_AP_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_beat))
   // an add acknowledgment carries a zero total
   `RARST_AP_SAME(a_add_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata == '0)
   // one command at a time: busy right after a beat is taken
   `RARST_AP_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)
   // reset starts the clearing pass with no result pending
   `RARST_AP_NEXT_ALWAYS(a_reset_quiet, reset, !req_tready && !rsp_tvalid)

endmodule

bind range_add_range_sum_tree rarst_check u_rarst_check (.*);
